[src/svv_pkg.sv]
package svv_pkg;

  typedef enum logic [3:0] {
    ST_MAJ_START = 4'd0,
    ST_MAJ_ZERO  = 4'd1,
    ST_MAJ_DIG   = 4'd2,
    ST_MIN_START = 4'd3,
    ST_MIN_ZERO  = 4'd4,
    ST_MIN_DIG   = 4'd5,
    ST_PAT_START = 4'd6,
    ST_PAT_ZERO  = 4'd7,
    ST_PAT_DIG   = 4'd8,
    ST_PRE_START = 4'd9,
    ST_PRE_IN    = 4'd10,
    ST_BLD_START = 4'd11,
    ST_BLD_IN    = 4'd12,
    ST_FAIL      = 4'd13
  } rec_state_t;

  typedef struct packed {
    logic is_zero;
    logic is_digit;
    logic is_ident;
    logic is_dot;
    logic is_dash;
    logic is_plus;
  } char_class_t;

  typedef struct packed {
    rec_state_t state;
    logic       accept;
  } step_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

endpackage

[src/svv_char_class.sv]
module svv_char_class (
  input  logic [7:0]           char_byte,
  output svv_pkg::char_class_t cls
);

  logic digit;

  assign digit = (char_byte >= svv_pkg::CH_ZERO) && (char_byte <= svv_pkg::CH_NINE);

  always_comb begin
    cls.is_zero  = (char_byte == svv_pkg::CH_ZERO);
    cls.is_digit = digit;
    cls.is_dot   = (char_byte == svv_pkg::CH_DOT);
    cls.is_dash  = (char_byte == svv_pkg::CH_DASH);
    cls.is_plus  = (char_byte == svv_pkg::CH_PLUS);
    cls.is_ident = digit ||
                   ((char_byte >= svv_pkg::CH_UP_A) && (char_byte <= svv_pkg::CH_UP_Z)) ||
                   ((char_byte >= svv_pkg::CH_LO_A) && (char_byte <= svv_pkg::CH_LO_Z)) ||
                   (char_byte == svv_pkg::CH_DASH);
  end

endmodule

[src/svv_next_state.sv]
module svv_next_state (
  input  svv_pkg::rec_state_t  state,
  input  svv_pkg::char_class_t cls,
  output svv_pkg::step_t       step
);

  svv_pkg::rec_state_t ns;

  always_comb begin
    ns = svv_pkg::ST_FAIL;
    unique case (state)
      svv_pkg::ST_MAJ_START: begin
        if (cls.is_zero) ns = svv_pkg::ST_MAJ_ZERO;
        else if (cls.is_digit) ns = svv_pkg::ST_MAJ_DIG;
      end
      svv_pkg::ST_MAJ_ZERO: begin
        if (cls.is_dot) ns = svv_pkg::ST_MIN_START;
      end
      svv_pkg::ST_MAJ_DIG: begin
        if (cls.is_digit) ns = svv_pkg::ST_MAJ_DIG;
        else if (cls.is_dot) ns = svv_pkg::ST_MIN_START;
      end
      svv_pkg::ST_MIN_START: begin
        if (cls.is_zero) ns = svv_pkg::ST_MIN_ZERO;
        else if (cls.is_digit) ns = svv_pkg::ST_MIN_DIG;
      end
      svv_pkg::ST_MIN_ZERO: begin
        if (cls.is_dot) ns = svv_pkg::ST_PAT_START;
      end
      svv_pkg::ST_MIN_DIG: begin
        if (cls.is_digit) ns = svv_pkg::ST_MIN_DIG;
        else if (cls.is_dot) ns = svv_pkg::ST_PAT_START;
      end
      svv_pkg::ST_PAT_START: begin
        if (cls.is_zero) ns = svv_pkg::ST_PAT_ZERO;
        else if (cls.is_digit) ns = svv_pkg::ST_PAT_DIG;
      end
      svv_pkg::ST_PAT_ZERO: begin
        if (cls.is_dash) ns = svv_pkg::ST_PRE_START;
        else if (cls.is_plus) ns = svv_pkg::ST_BLD_START;
      end
      svv_pkg::ST_PAT_DIG: begin
        if (cls.is_digit) ns = svv_pkg::ST_PAT_DIG;
        else if (cls.is_dash) ns = svv_pkg::ST_PRE_START;
        else if (cls.is_plus) ns = svv_pkg::ST_BLD_START;
      end
      svv_pkg::ST_PRE_START: begin
        if (cls.is_ident) ns = svv_pkg::ST_PRE_IN;
      end
      svv_pkg::ST_PRE_IN: begin
        if (cls.is_ident) ns = svv_pkg::ST_PRE_IN;
        else if (cls.is_dot) ns = svv_pkg::ST_PRE_START;
        else if (cls.is_plus) ns = svv_pkg::ST_BLD_START;
      end
      svv_pkg::ST_BLD_START: begin
        if (cls.is_ident) ns = svv_pkg::ST_BLD_IN;
      end
      svv_pkg::ST_BLD_IN: begin
        if (cls.is_ident) ns = svv_pkg::ST_BLD_IN;
        else if (cls.is_dot) ns = svv_pkg::ST_BLD_START;
      end
      default: ns = svv_pkg::ST_FAIL;
    endcase
  end

  always_comb begin
    step.state  = ns;
    step.accept = (ns == svv_pkg::ST_PAT_ZERO) || (ns == svv_pkg::ST_PAT_DIG) ||
                  (ns == svv_pkg::ST_PRE_IN) || (ns == svv_pkg::ST_BLD_IN);
  end

endmodule

[src/semver_string_validator_core.sv]
// A last byte is taken into the input register, and its result is then
// registered in the result register.
// Throughput: one byte per cycle; the recognizer state register and its
// next-state logic close a loop. A last byte holds in the input
// register only while an earlier result is still stalled at the output.
// Reset (rst, synchronous): empties both registers and returns to major start.
module semver_string_validator_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_valid
);

  logic                in_reg_valid;
  logic [7:0]          in_byte;
  logic                in_last;
  svv_pkg::rec_state_t state;
  svv_pkg::char_class_t cls;
  svv_pkg::step_t      step;
  logic                out_free;
  logic                advance;

  svv_char_class u_class (
    .char_byte (in_byte),
    .cls       (cls)
  );

  svv_next_state u_next (
    .state (state),
    .cls   (cls),
    .step  (step)
  );

  assign out_free = !out_valid || !out_stall;
  assign advance  = in_reg_valid && (!in_last || out_free);
  assign in_stall = in_reg_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      state        <= svv_pkg::ST_MAJ_START;
      out_valid    <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_reg_valid <= in_valid;
      end
      if (advance) begin
        state <= in_last ? svv_pkg::ST_MAJ_START : step.state;
      end
      if (advance && in_last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte <= char_byte;
      in_last <= last_byte;
    end
    if (advance && in_last) begin
      is_valid <= step.accept;
    end
  end

`ifndef SYNTHESIS
  a_reset_start: assert property (@(posedge clk)
    rst |=> state == svv_pkg::ST_MAJ_START)
    else $error("state not at start after reset");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> state == svv_pkg::ST_MAJ_START)
    else $error("state not at start after last byte");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> out_valid)
    else $error("last byte gave no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_reg_valid && in_last && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_result_drains: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !(advance && in_last) |=> !out_valid)
    else $error("taken result not dropped");
`endif

endmodule

[sim/tb.sv]
module tb;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } byte_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       is_valid;

  byte_item_t pending_q[$];
  logic [7:0] word_q[$];
  logic       verdict_q[$];
  svv_pkg::rec_state_t scan_state = svv_pkg::ST_MAJ_START;
  logic       in_taken = 1'b0;
  logic       hold_on = 1'b0;
  int         total_bytes = 1;
  int         byte_count = 0;
  int         phase = 0;
  int         mismatches = 0;

  semver_string_validator_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .char_byte(char_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .is_valid(is_valid)
  );

  always #1 clk = ~clk;

  function automatic logic is_num(logic [7:0] c);
    return c >= svv_pkg::CH_ZERO && c <= svv_pkg::CH_NINE;
  endfunction

  function automatic logic is_id_char(logic [7:0] c);
    return is_num(c) || (c >= svv_pkg::CH_UP_A && c <= svv_pkg::CH_UP_Z) ||
           (c >= svv_pkg::CH_LO_A && c <= svv_pkg::CH_LO_Z) || c == svv_pkg::CH_DASH;
  endfunction

  function automatic svv_pkg::rec_state_t semver_next(svv_pkg::rec_state_t s,
                                                      logic [7:0] c);
    svv_pkg::rec_state_t ns;
    ns = svv_pkg::ST_FAIL;
    case (s)
      svv_pkg::ST_MAJ_START, svv_pkg::ST_MIN_START, svv_pkg::ST_PAT_START: begin
        if (c == svv_pkg::CH_ZERO) ns = svv_pkg::rec_state_t'(s + 4'd1);
        else if (is_num(c)) ns = svv_pkg::rec_state_t'(s + 4'd2);
      end
      svv_pkg::ST_MAJ_ZERO, svv_pkg::ST_MAJ_DIG: begin
        if (s == svv_pkg::ST_MAJ_DIG && is_num(c)) ns = s;
        else if (c == svv_pkg::CH_DOT) ns = svv_pkg::ST_MIN_START;
      end
      svv_pkg::ST_MIN_ZERO, svv_pkg::ST_MIN_DIG: begin
        if (s == svv_pkg::ST_MIN_DIG && is_num(c)) ns = s;
        else if (c == svv_pkg::CH_DOT) ns = svv_pkg::ST_PAT_START;
      end
      svv_pkg::ST_PAT_ZERO, svv_pkg::ST_PAT_DIG: begin
        if (s == svv_pkg::ST_PAT_DIG && is_num(c)) ns = s;
        else if (c == svv_pkg::CH_DASH) ns = svv_pkg::ST_PRE_START;
        else if (c == svv_pkg::CH_PLUS) ns = svv_pkg::ST_BLD_START;
      end
      svv_pkg::ST_PRE_START: begin
        if (is_id_char(c)) ns = svv_pkg::ST_PRE_IN;
      end
      svv_pkg::ST_PRE_IN: begin
        if (is_id_char(c)) ns = svv_pkg::ST_PRE_IN;
        else if (c == svv_pkg::CH_DOT) ns = svv_pkg::ST_PRE_START;
        else if (c == svv_pkg::CH_PLUS) ns = svv_pkg::ST_BLD_START;
      end
      svv_pkg::ST_BLD_START: begin
        if (is_id_char(c)) ns = svv_pkg::ST_BLD_IN;
      end
      svv_pkg::ST_BLD_IN: begin
        if (is_id_char(c)) ns = svv_pkg::ST_BLD_IN;
        else if (c == svv_pkg::CH_DOT) ns = svv_pkg::ST_BLD_START;
      end
      default: ns = svv_pkg::ST_FAIL;
    endcase
    return ns;
  endfunction

  task automatic flag_mismatch(input string what, input logic want, input logic got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected is_valid=%b, got %b", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : check_p
    logic                want;
    svv_pkg::rec_state_t ns;
    if (rst) begin
      scan_state = svv_pkg::ST_MAJ_START;
      in_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch("unexpected result", 1'bx, is_valid);
        end else begin
          want = verdict_q.pop_front();
          if (is_valid !== want) flag_mismatch("wrong verdict", want, is_valid);
        end
      end
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        ns = semver_next(scan_state, char_byte);
        byte_count++;
        phase = (byte_count * 3) / total_bytes;
        if (last_byte) begin
          want = (ns == svv_pkg::ST_PAT_ZERO || ns == svv_pkg::ST_PAT_DIG ||
                  ns == svv_pkg::ST_PRE_IN || ns == svv_pkg::ST_BLD_IN);
          verdict_q.insert(verdict_q.size(), want);
          scan_state = svv_pkg::ST_MAJ_START;
        end else begin
          scan_state = ns;
        end
      end
    end
  end

  always @(negedge clk) begin : drive_p
    byte_item_t it;
    int         send_idle;
    send_idle = (phase == 0) ? 38 : (phase == 1) ? 50 : 0;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (pending_q.size() != 0 && $urandom_range(99) >= send_idle) begin
      it = pending_q.pop_front();
      char_byte <= it.ch;
      last_byte <= it.last;
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin : stall_p
    int recv_idle;
    recv_idle = (phase == 0) ? 50 : (phase == 1) ? 38 : 0;
    out_stall <= hold_on || ($urandom_range(99) < recv_idle);
  end

  initial begin
    while (rst) @(posedge clk);
    repeat (300) @(posedge clk);
    hold_on = 1'b1;
    repeat (200) @(posedge clk);
    hold_on = 1'b0;
  end

  task automatic put_char(input logic [7:0] c);
    word_q.insert(word_q.size(), c);
  endtask

  task automatic flush_word();
    byte_item_t it;
    for (int i = 0; i < word_q.size(); i++) begin
      it.ch = word_q[i];
      it.last = (i == word_q.size() - 1);
      pending_q.insert(pending_q.size(), it);
    end
    word_q.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  task automatic add_number();
    int n;
    if ($urandom_range(19) == 0) begin
      put_char(svv_pkg::CH_ZERO);
      put_char(8'(svv_pkg::CH_ZERO + $urandom_range(9)));
    end else if ($urandom_range(9) < 3) begin
      put_char(svv_pkg::CH_ZERO);
    end else begin
      put_char(8'(svv_pkg::CH_ZERO + $urandom_range(9, 1)));
      n = $urandom_range(3);
      repeat (n) put_char(8'(svv_pkg::CH_ZERO + $urandom_range(9)));
    end
  endtask

  task automatic add_ids();
    int n;
    int len;
    int r;
    n = $urandom_range(3, 1);
    for (int i = 0; i < n; i++) begin
      if (i != 0) put_char(svv_pkg::CH_DOT);
      len = $urandom_range(4, 1);
      repeat (len) begin
        r = $urandom_range(62);
        if (r < 10) put_char(8'(svv_pkg::CH_ZERO + r));
        else if (r < 36) put_char(8'(svv_pkg::CH_UP_A + r - 10));
        else if (r < 62) put_char(8'(svv_pkg::CH_LO_A + r - 36));
        else put_char(svv_pkg::CH_DASH);
      end
    end
  endtask

  initial begin
    int kind;
    int pos;

    add_text("0.0.0");
    flush_word();
    add_text("10.2.39-0A.z+-");
    flush_word();
    add_text("01.1.1");
    flush_word();
    put_char(8'hFF);
    flush_word();
    put_char(8'h00);
    flush_word();

    while (pending_q.size() < 1600) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        repeat ($urandom_range(6, 1)) put_char(8'($urandom_range(255)));
      end else begin
        add_number();
        put_char(svv_pkg::CH_DOT);
        add_number();
        put_char(svv_pkg::CH_DOT);
        add_number();
        if ($urandom_range(1)) begin
          put_char(svv_pkg::CH_DASH);
          add_ids();
        end
        if ($urandom_range(1)) begin
          put_char(svv_pkg::CH_PLUS);
          add_ids();
        end
        if (kind < 35) begin
          pos = $urandom_range(word_q.size() - 1);
          case ($urandom_range(2))
            0: word_q[pos] = 8'($urandom_range(255));
            1: word_q.delete(pos);
            default: word_q.insert(pos, 8'($urandom_range(255)));
          endcase
        end
      end
      flush_word();
    end
    total_bytes = pending_q.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("semver_string_validator_core: match");
    end else begin
      $display("semver_string_validator_core: mismatch");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("semver_string_validator_core: mismatch");
    $finish;
  end

endmodule

[sim.f]
src/svv_pkg.sv
src/svv_char_class.sv
src/svv_next_state.sv
src/semver_string_validator_core.sv
sim/tb.sv
